// File: sv/pbfs_pkg.sv
// ----------------------------------------------------------------------------
// pbfs_pkg
// Shared types and constants for the protobuf field scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbfs_pkg;

    localparam int PBFS_MAX_BYTES = 512;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FIELD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_KIND   = 1'b1;

    // result status codes
    localparam logic [1:0] ST_NOT_FOUND = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  data_offset;
        logic [9:0]  data_length;
        logic [31:0] varint_value;
    } result_t;

    typedef struct packed {
        logic [28:0] target_field;
        logic        field_kind;
    } cfg_t;

endpackage

// File: sv/protobuf_field_scanner.sv
// ----------------------------------------------------------------------------
// protobuf_field_scanner
// Scans a protobuf message byte by byte and reports the first field with the
// configured number (length-delimited or varint, per field_kind).
// ----------------------------------------------------------------------------
// One message byte is taken per clock cycle unless the input stalls; the
// whole decoder update for a byte is combinational logic feeding the scan
// state registers. One result per message is presented the cycle after its
// last byte transfers and sits in an output register until taken. Input stalls
// only when a last byte arrives while the previous result is still held and
// stalled. The user is to write target_field and field_kind through the cfg
// port only between messages; the block itself does not enforce this.
`timescale 1ns / 1ps

module protobuf_field_scanner
    import pbfs_pkg::*;
#(
    parameter int MAX_BYTES = PBFS_MAX_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    accept;
    logic    result_valid_reg;
    result_t result_reg;
    result_t dec_result;
    cfg_t    cfg_reg;

    assign cfg_ready    = 1'b1;
    assign item_stall   = result_valid_reg && result_stall && item.last_byte;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_field <= 29'd1;
            cfg_reg.field_kind   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TARGET_FIELD: cfg_reg.target_field <= cfg_data[28:0];
                CFG_FIELD_KIND:   cfg_reg.field_kind   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    pbfs_decoder #(
        .MAX_BYTES (MAX_BYTES)
    ) u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .result (dec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept && item.last_byte)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.last_byte)
        begin
            result_reg <= dec_result;
        end
    end

    // every last-byte transfer produces a result on the next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item.last_byte) |=> result_valid)
        else $error("no result after last byte");

    // a new result appears only after a last-byte transfer
    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && !item_stall && item.last_byte))
        else $error("result without last byte");

    // payload fields are zero unless the field was found
    a_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != ST_FOUND)) |->
        ((result.data_offset == 9'd0) && (result.data_length == 10'd0) &&
         (result.varint_value == 32'd0)))
        else $error("nonzero payload on not-found result");

    // the two modes never both report payload
    a_one_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.varint_value != 32'd0)) |->
        ((result.data_offset == 9'd0) && (result.data_length == 10'd0)))
        else $error("length and varint result mixed");

endmodule

// File: sv/pbfs_decoder.sv
// ----------------------------------------------------------------------------
// pbfs_decoder
// Per-byte wire-format decoder: tag/varint accumulation, payload skipping,
// match capture and end-of-message result formation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbfs_decoder
    import pbfs_pkg::*;
#(
    parameter int MAX_BYTES = PBFS_MAX_BYTES
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int POS_W = $clog2(MAX_BYTES + 2);

    localparam logic [2:0] PH_TAG   = 3'd0;
    localparam logic [2:0] PH_VALUE = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_SKIP  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    typedef struct packed {
        logic [2:0]       phase;
        logic [31:0]      acc;
        logic [5:0]       shift;
        logic [31:0]      skip;
        logic [POS_W-1:0] pos;
        logic [28:0]      cur_field;
        logic [2:0]       cur_wire;
        logic             seen;
        logic [POS_W-1:0] moff;
        logic [31:0]      mval;
        logic             too_long;
        logic             is_len;
    } scan_t;

    scan_t scan_reg;
    scan_t scan_next;
    scan_t s;
    logic  cont;
    logic [32:0] end_pos;

    function automatic scan_t start_varint(scan_t st);
        st.acc   = '0;
        st.shift = '0;
        return st;
    endfunction

    function automatic scan_t accumulate(scan_t st, logic [7:0] b);
        if (st.shift < 6'd32)
        begin
            st.acc = st.acc | ({25'd0, b[6:0]} << st.shift[4:0]);
        end
        // saturate at 63
        if (st.shift > 6'd56)
        begin
            st.shift = 6'd63;
        end
        else
        begin
            st.shift = st.shift + 6'd7;
        end
        return st;
    endfunction

    function automatic scan_t dispatch(scan_t st);
        st.cur_field = st.acc[31:3];
        st.cur_wire  = st.acc[2:0];
        st = start_varint(st);
        case (st.cur_wire)
            WT_VARINT: st.phase = PH_VALUE;
            WT_LEN:    st.phase = PH_LEN;
            WT_FIX32:
            begin
                st.phase = PH_SKIP;
                st.skip  = 32'd4;
            end
            WT_FIX64:
            begin
                st.phase = PH_SKIP;
                st.skip  = 32'd8;
            end
            default:   st.phase = PH_DONE;
        endcase
        return st;
    endfunction

    function automatic scan_t value_done(scan_t st, cfg_t c);
        if (c.field_kind && (st.cur_field == c.target_field))
        begin
            st.seen   = 1'b1;
            st.is_len = 1'b0;
            st.mval   = st.acc;
            st.phase  = PH_DONE;
        end
        else
        begin
            st.phase = PH_TAG;
        end
        st = start_varint(st);
        return st;
    endfunction

    function automatic scan_t length_done(scan_t st, cfg_t c);
        logic [31:0] len;
        len = st.acc;
        st = start_varint(st);
        if (!c.field_kind && (st.cur_field == c.target_field))
        begin
            st.seen   = 1'b1;
            st.is_len = 1'b1;
            st.moff   = st.pos;
            st.mval   = len;
            st.phase  = PH_DONE;
        end
        else if (len == 32'd0)
        begin
            st.phase = PH_TAG;
        end
        else
        begin
            st.skip  = len;
            st.phase = PH_SKIP;
        end
        return st;
    endfunction

    always_comb
    begin
        s       = scan_reg;
        cont    = item.data_byte[7];
        result  = '0;
        end_pos = '0;

        // byte count saturates one past the limit
        if (s.pos <= POS_W'(MAX_BYTES))
        begin
            s.pos = s.pos + POS_W'(1);
        end
        if (s.pos > POS_W'(MAX_BYTES))
        begin
            s.too_long = 1'b1;
        end

        case (s.phase)
            PH_TAG:
            begin
                s = accumulate(s, item.data_byte);
                if (!cont)
                begin
                    s = dispatch(s);
                end
            end
            PH_VALUE:
            begin
                s = accumulate(s, item.data_byte);
                if (!cont)
                begin
                    s = value_done(s, cfg);
                end
            end
            PH_LEN:
            begin
                s = accumulate(s, item.data_byte);
                if (!cont)
                begin
                    s = length_done(s, cfg);
                end
            end
            PH_SKIP:
            begin
                if (s.skip != 32'd0)
                begin
                    s.skip = s.skip - 32'd1;
                end
                if (s.skip == 32'd0)
                begin
                    s.phase = PH_TAG;
                end
            end
            default:
            begin
            end
        endcase

        if (item.last_byte)
        begin
            // close out any varint still open at end of message
            if ((s.phase == PH_TAG) && (s.shift != 6'd0))
            begin
                s = dispatch(s);
            end
            if (s.phase == PH_VALUE)
            begin
                s = value_done(s, cfg);
            end
            else if (s.phase == PH_LEN)
            begin
                s = length_done(s, cfg);
            end

            end_pos = {1'b0, s.mval} + 33'(s.moff);
            if (s.too_long)
            begin
                result.status = ST_TOO_LONG;
            end
            else if (s.seen)
            begin
                if (s.is_len)
                begin
                    // payload must fit inside the message
                    if (end_pos <= 33'(s.pos))
                    begin
                        result.status      = ST_FOUND;
                        result.data_offset = 9'(s.moff);
                        result.data_length = s.mval[9:0];
                    end
                end
                else
                begin
                    result.status       = ST_FOUND;
                    result.varint_value = s.mval;
                end
            end
        end

        scan_next = item.last_byte ? scan_t'('0) : s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else if (accept)
        begin
            scan_reg <= scan_next;
        end
    end

endmodule
